/* design/pgu_pkg.sv */
// Package for the packed genotype unpacker.
// Holds widths, header codes, register indexes, result structs and the code table.
// No dependencies; imported by every module in design/.
package pgu_pkg;

  localparam int IDX_W     = 20;  // counter, register and index width
  localparam int LANES     = 4;   // 2-bit codes per byte
  localparam int LANE_BITS = $clog2(LANES);
  localparam int CNT_W     = $clog2(LANES + 1);
  localparam int ADDR_W    = 3;

  localparam logic [7:0] MAGIC_FIRST  = 8'h6C;
  localparam logic [7:0] MAGIC_SECOND = 8'h1B;

  // register index as seen on paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // header tracking
  typedef enum logic [1:0] {
    HDR_FIRST  = 2'd0,
    HDR_SECOND = 2'd1,
    HDR_LAYOUT = 2'd2,
    HDR_DATA   = 2'd3
  } hdr_pos_t;

  // 2-bit file codes
  localparam logic [1:0] CODE_HOM_FIRST = 2'b00;
  localparam logic [1:0] CODE_MISSING   = 2'b01;
  localparam logic [1:0] CODE_HET       = 2'b10;
  localparam logic [1:0] CODE_HOM_OTHER = 2'b11;

  localparam logic [1:0] GENO_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]       genotype;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             last_of_byte;
    logic             matrix_done;
    logic             bad_header;
  } result_t;

  // what one lane found for its code
  typedef struct packed {
    result_t res;
    logic    run_end;    // inner run ends at this code
    logic    outer_end;  // and the whole matrix with it
  } lane_out_t;

  // merged view of one byte, back to the counter logic
  typedef struct packed {
    logic any_end;
    logic matrix_end;
  } merge_sum_t;

  function automatic logic [1:0] code_to_count(input logic [1:0] code);
    logic [1:0] g;
    case (code)
      CODE_HOM_FIRST: g = 2'd0;
      CODE_MISSING:   g = GENO_MISSING;
      CODE_HET:       g = 2'd1;
      CODE_HOM_OTHER: g = 2'd2;
      default:        g = GENO_MISSING;
    endcase
    return g;
  endfunction

endpackage

/* design/packed_genotype_unpacker.sv */
// Top level of the packed genotype unpacker: config registers, header check,
// matrix counters, four decode lanes and the merge stage.
// Depends on pgu_pkg, pgu_lane, pgu_merge.
//
//   channel  | signals                                | direction
//   ---------+----------------------------------------+----------
//   config   | psel penable pwrite paddr pwdata prdata| in / out
//   input    | in_valid in_ready data_byte            | in
//   output   | out_valid out_ready genotype row_index | out
//            | col_index last_of_byte matrix_done     |
//            | bad_header                             |
//
// A data byte yields one result per code up to the first run end, drained through the
// single-result output register; good header bytes and ignored bytes yield none.
// The next byte is taken when the last result of the previous one moves into the
// output register; while results wait, a stalled output holds in_ready low.
// Synchronous reset clears counters, header state and the result buffer;
// row_count and col_count reset to 1.
module packed_genotype_unpacker (
  input  logic                          clk,
  input  logic                          rst,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pgu_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    genotype,
  output logic [pgu_pkg::IDX_W-1:0]     row_index,
  output logic [pgu_pkg::IDX_W-1:0]     col_index,
  output logic                          last_of_byte,
  output logic                          matrix_done,
  output logic                          bad_header
);
  import pgu_pkg::*;

  logic [IDX_W-1:0] row_count;
  logic [IDX_W-1:0] col_count;
  hdr_pos_t         hdr_pos;
  hdr_pos_t         hdr_pos_next;
  logic             variant_major;
  logic             variant_major_next;
  logic [IDX_W-1:0] inner;
  logic [IDX_W-1:0] inner_next;
  logic [IDX_W-1:0] outer;
  logic [IDX_W-1:0] outer_next;
  logic             finished;
  logic             finished_next;
  logic             error_seen;
  logic             error_seen_next;

  logic             accept;
  logic             room;
  logic             load_lanes;
  logic             load_error;
  logic [IDX_W-1:0] inner_len;
  logic [IDX_W-1:0] outer_len;
  lane_out_t [LANES-1:0] lanes;
  merge_sum_t       sum;
  result_t          out_res;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= IDX_W'(1);
      col_count <= IDX_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ROW_COUNT: row_count <= pwdata[IDX_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_COUNT: prdata = 32'(row_count);
      REG_COL_COUNT: prdata = 32'(col_count);
      default:       prdata = '0;
    endcase
  end

  assign in_ready  = room;
  assign accept    = in_valid && in_ready;
  assign inner_len = variant_major ? row_count : col_count;
  assign outer_len = variant_major ? col_count : row_count;

  // decode lanes, one per 2-bit code
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    pgu_lane u_lane (
      .lane_id       (LANE_BITS'(i)),
      .code          (data_byte[2*i +: 2]),
      .inner         (inner),
      .outer         (outer),
      .inner_len     (inner_len),
      .outer_len     (outer_len),
      .variant_major (variant_major),
      .lane          (lanes[i])
    );
  end

  pgu_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load_lanes (load_lanes),
    .load_error (load_error),
    .lanes      (lanes),
    .sum        (sum),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // header check and matrix counters
  always_comb begin
    hdr_pos_next       = hdr_pos;
    variant_major_next = variant_major;
    inner_next         = inner;
    outer_next         = outer;
    finished_next      = finished;
    error_seen_next    = error_seen;
    load_lanes         = 1'b0;
    load_error         = 1'b0;
    if (accept) begin
      if (error_seen) begin
        load_error = 1'b1;
      end else if (hdr_pos != HDR_DATA) begin
        if ((hdr_pos == HDR_FIRST && data_byte != MAGIC_FIRST) ||
            (hdr_pos == HDR_SECOND && data_byte != MAGIC_SECOND)) begin
          error_seen_next = 1'b1;
          load_error      = 1'b1;
        end else begin
          if (hdr_pos == HDR_LAYOUT) begin
            variant_major_next = (data_byte != 8'd0);
          end
          case (hdr_pos)
            HDR_FIRST:  hdr_pos_next = HDR_SECOND;
            HDR_SECOND: hdr_pos_next = HDR_LAYOUT;
            default:    hdr_pos_next = HDR_DATA;
          endcase
        end
      end else if (!finished) begin
        load_lanes = 1'b1;
        if (sum.any_end) begin
          inner_next = '0;
          if (sum.matrix_end) begin
            outer_next    = '0;
            finished_next = 1'b1;
          end else begin
            outer_next = outer + IDX_W'(1);
          end
        end else begin
          inner_next = inner + IDX_W'(LANES);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos       <= HDR_FIRST;
      variant_major <= 1'b0;
      inner         <= '0;
      outer         <= '0;
      finished      <= 1'b0;
      error_seen    <= 1'b0;
    end else begin
      hdr_pos       <= hdr_pos_next;
      variant_major <= variant_major_next;
      inner         <= inner_next;
      outer         <= outer_next;
      finished      <= finished_next;
      error_seen    <= error_seen_next;
    end
  end

  assign genotype     = out_res.genotype;
  assign row_index    = out_res.row_index;
  assign col_index    = out_res.col_index;
  assign last_of_byte = out_res.last_of_byte;
  assign matrix_done  = out_res.matrix_done;
  assign bad_header   = out_res.bad_header;

endmodule

/* design/pgu_lane.sv */
// One decode lane: maps a 2-bit code to a genotype and works out its position.
// Depends on pgu_pkg.
module pgu_lane (
  input  logic [pgu_pkg::LANE_BITS-1:0] lane_id,
  input  logic [1:0]                    code,
  input  logic [pgu_pkg::IDX_W-1:0]     inner,
  input  logic [pgu_pkg::IDX_W-1:0]     outer,
  input  logic [pgu_pkg::IDX_W-1:0]     inner_len,
  input  logic [pgu_pkg::IDX_W-1:0]     outer_len,
  input  logic                          variant_major,
  output pgu_pkg::lane_out_t            lane
);
  import pgu_pkg::*;

  logic [IDX_W-1:0] pos;
  logic [IDX_W:0]   next_inner;
  logic [IDX_W:0]   next_outer;
  logic             run_end;

  // position of this code assuming no earlier lane ended the run
  assign pos        = inner + IDX_W'(lane_id);
  assign next_inner = {1'b0, inner} + (IDX_W+1)'(lane_id) + (IDX_W+1)'(1);
  assign next_outer = {1'b0, outer} + (IDX_W+1)'(1);
  // wider compare also covers counter wrap; zero length ends at once
  assign run_end    = next_inner >= {1'b0, inner_len};

  always_comb begin
    lane.res.genotype     = code_to_count(code);
    lane.res.row_index    = variant_major ? pos : outer;
    lane.res.col_index    = variant_major ? outer : pos;
    lane.res.last_of_byte = run_end || (lane_id == LANE_BITS'(LANES - 1));
    lane.res.matrix_done  = run_end && (next_outer >= {1'b0, outer_len});
    lane.res.bad_header   = 1'b0;
    lane.run_end          = run_end;
    lane.outer_end        = run_end && (next_outer >= {1'b0, outer_len});
  end

endmodule

/* design/pgu_merge.sv */
// Merge stage: cuts lane results at the first run end, buffers them and drains
// them to the output register, one per cycle unless stalled. Depends on pgu_pkg.
module pgu_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load_lanes,
  input  logic                                  load_error,
  input  pgu_pkg::lane_out_t [pgu_pkg::LANES-1:0] lanes,
  output pgu_pkg::merge_sum_t                   sum,
  output logic                                  room,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pgu_pkg::result_t                      out_res
);
  import pgu_pkg::*;

  result_t          buffer [LANES];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] take;
  logic             pop;
  result_t          err_res;

  // first lane that ends the run sets the count
  always_comb begin
    take           = CNT_W'(LANES);
    sum.any_end    = 1'b0;
    sum.matrix_end = 1'b0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (lanes[k].run_end) begin
        take           = CNT_W'(k + 1);
        sum.any_end    = 1'b1;
        sum.matrix_end = lanes[k].outer_end;
      end
    end
  end

  always_comb begin
    err_res              = '0;
    err_res.last_of_byte = 1'b1;
    err_res.bad_header   = 1'b1;
  end

  assign pop  = (cnt != '0) && (!out_valid || out_ready);
  assign room = (cnt == '0) || ((cnt == CNT_W'(1)) && pop);

  always_comb begin
    cnt_next = cnt;
    if (pop) begin
      cnt_next = cnt - CNT_W'(1);
    end
    if (load_lanes) begin
      cnt_next = take;
    end else if (load_error) begin
      cnt_next = CNT_W'(1);
    end
  end

  // result buffer, head at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    if (load_lanes) begin
      for (int k = 0; k < LANES; k++) begin
        buffer[k] <= lanes[k].res;
      end
    end else if (load_error) begin
      buffer[0] <= err_res;
    end else if (pop) begin
      for (int k = 0; k < LANES - 1; k++) begin
        buffer[k] <= buffer[k+1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      out_res <= buffer[0];
    end
  end

endmodule
